@@ sv/jmbd_pkg.sv @@
// Package for the Japanese multibyte decoder: decode phases, result kinds,
// character-set constants and the decoder result struct.
// No dependencies; used by the decoder, the top level and the testbench.
package jmbd_pkg;

  // Decode phase: what the next byte means
  typedef enum logic [2:0] {
    PH_LEAD      = 3'd0,
    PH_J208      = 3'd1,
    PH_EUDC      = 3'd2,
    PH_REPLACE   = 3'd3,
    PH_KANA      = 3'd4,
    PH_J212_LEAD = 3'd5,
    PH_J212_TRL  = 3'd6
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_DIRECT = 2'd0;
  localparam logic [1:0] KIND_J208   = 2'd1;
  localparam logic [1:0] KIND_J212   = 2'd2;

  localparam logic       MODE_SJIS   = 1'b0;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [15:0] KANA_BIAS   = 16'hFF61 - 16'h00A1;
  localparam logic [15:0] EUDC_BASE   = 16'hE000;
  localparam logic [15:0] SJIS_ROW    = 16'd188;
  localparam logic [15:0] EUC_ROW     = 16'd94;
  localparam logic [7:0]  EUC_SS2     = 8'h8E;
  localparam logic [7:0]  EUC_SS3     = 8'h8F;
  localparam logic [7:0]  ASCII_MAX   = 8'h7F;

  // Decoder outcome for one byte
  typedef struct packed {
    logic        emit;
    logic [1:0]  kind;
    logic [15:0] value;
    phase_t      phase_nxt;
    logic [15:0] base_nxt;
  } dec_t;

endpackage

@@ sv/jmbd_in_if.sv @@
// Input channel of the Japanese multibyte decoder: one encoded byte per item.
// Valid/ready handshake; no dependencies.
interface jmbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

@@ sv/jmbd_out_if.sv @@
// Result channel of the Japanese multibyte decoder: kind and code value.
// Valid/ready handshake; no dependencies.
interface jmbd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] code_value;

  modport source (output valid, output result_kind, output code_value, input ready);
  modport sink   (input valid, input result_kind, input code_value, output ready);
endinterface

@@ sv/japanese_multibyte_to_unicode_decoder_unit.sv @@
// Top level of the Shift_JIS / EUC-JP to Unicode decoder.
// Path: an accepted byte waits in the input byte register; its result goes into the
// result register when the decode fires, which waits while that register is full.
// Throughput: one byte per cycle while the result register is not held full, set by the
// combinational decode between the input byte register and the result register.
// Reset (rst_n, synchronous, active low): Shift_JIS mode, lead phase, no items held.
// Depends on jmbd_pkg, jmbd_in_if, jmbd_out_if and jmbd_decode.
module japanese_multibyte_to_unicode_decoder_unit (
  input  logic              clk,
  input  logic              rst_n,
  jmbd_in_if.sink           in_ch,
  jmbd_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  // Input stage: one byte waiting for decode
  logic             in_valid_r, in_valid_nxt;
  logic [7:0]       in_byte_r;

  // Decoder state
  logic             mode_r;
  jmbd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      base_r, base_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r;
  logic [15:0]      out_value_r;

  jmbd_pkg::dec_t   dec;
  logic             in_fire;
  logic             dec_fire;
  logic             out_take;

  jmbd_decode u_decode (
    .mode    (mode_r),
    .phase   (phase_r),
    .base    (base_r),
    .byte_in (in_byte_r),
    .dec     (dec)
  );

  // The held byte advances when it makes no result, or when the result
  // register is empty or being emptied this cycle.
  assign out_take = out_valid_r & out_ch.ready;
  assign dec_fire = in_valid_r & (~dec.emit | ~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~in_valid_r | dec_fire;
  assign in_fire = in_ch.valid & in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (dec_fire) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (dec_fire && dec.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    phase_nxt = phase_r;
    base_nxt  = base_r;
    if (dec_fire) begin
      phase_nxt = dec.phase_nxt;
      base_nxt  = dec.base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= jmbd_pkg::MODE_SJIS;
      phase_r     <= jmbd_pkg::PH_LEAD;
      base_r      <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        // mode change: drop any partial character
        mode_r  <= cfg_wr_data;
        phase_r <= jmbd_pkg::PH_LEAD;
        base_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        base_r  <= base_nxt;
      end
    end
  end

  // Payload registers: hold until replaced
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.byte_in;
    end
    if (dec_fire && dec.emit) begin
      out_kind_r  <= dec.kind;
      out_value_r <= dec.value;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.code_value  = out_value_r;

endmodule

@@ sv/jmbd_decode.sv @@
// Combinational next-state and result logic for one byte of Shift_JIS or EUC-JP.
// Depends on jmbd_pkg.
module jmbd_decode (
  input  logic             mode,
  input  jmbd_pkg::phase_t phase,
  input  logic [15:0]      base,
  input  logic [7:0]       byte_in,
  output jmbd_pkg::dec_t   dec
);

  logic [7:0]  sjis_off;
  logic        sjis_ok;
  logic [7:0]  euc_off;
  logic        euc_ok;
  logic        kana_ok;
  logic [15:0] kana_code;

  always_comb begin
    sjis_ok  = 1'b1;
    sjis_off = byte_in - 8'h40;
    if (byte_in >= 8'h40 && byte_in <= 8'h7E) begin
      sjis_off = byte_in - 8'h40;
    end else if (byte_in >= 8'h80 && byte_in <= 8'hFC) begin
      sjis_off = byte_in - 8'h41;
    end else begin
      sjis_ok = 1'b0;
    end
    euc_ok    = (byte_in >= 8'hA1) && (byte_in <= 8'hFE);
    euc_off   = byte_in - 8'hA1;
    kana_ok   = (byte_in >= 8'hA1) && (byte_in <= 8'hDF);
    kana_code = jmbd_pkg::KANA_BIAS + 16'(byte_in);
  end

  always_comb begin
    dec           = '0;
    dec.kind      = jmbd_pkg::KIND_DIRECT;
    dec.value     = jmbd_pkg::REPLACEMENT;
    dec.phase_nxt = jmbd_pkg::PH_LEAD;
    dec.base_nxt  = base;
    unique case (phase)
      jmbd_pkg::PH_LEAD: begin
        if (byte_in <= jmbd_pkg::ASCII_MAX) begin
          dec.emit  = 1'b1;
          dec.value = 16'(byte_in);
        end else if (mode == jmbd_pkg::MODE_SJIS) begin
          if (byte_in >= 8'h81 && byte_in <= 8'h9F) begin
            dec.base_nxt  = 16'(8'(byte_in - 8'h81)) * jmbd_pkg::SJIS_ROW;
            dec.phase_nxt = jmbd_pkg::PH_J208;
          end else if (byte_in >= 8'hE0 && byte_in <= 8'hEF) begin
            dec.base_nxt  = 16'(8'(byte_in - 8'hC1)) * jmbd_pkg::SJIS_ROW;
            dec.phase_nxt = jmbd_pkg::PH_J208;
          end else if (kana_ok) begin
            dec.emit  = 1'b1;
            dec.value = kana_code;
          end else if (byte_in >= 8'hF0 && byte_in <= 8'hF9) begin
            dec.base_nxt  = jmbd_pkg::EUDC_BASE
                            + 16'(8'(byte_in - 8'hF0)) * jmbd_pkg::SJIS_ROW;
            dec.phase_nxt = jmbd_pkg::PH_EUDC;
          end else if (byte_in >= 8'hFA && byte_in <= 8'hFC) begin
            dec.phase_nxt = jmbd_pkg::PH_REPLACE;
          end
        end else if (euc_ok) begin
          dec.base_nxt  = 16'(euc_off) * jmbd_pkg::EUC_ROW;
          dec.phase_nxt = jmbd_pkg::PH_J208;
        end else if (byte_in == jmbd_pkg::EUC_SS2) begin
          dec.phase_nxt = jmbd_pkg::PH_KANA;
        end else if (byte_in == jmbd_pkg::EUC_SS3) begin
          dec.phase_nxt = jmbd_pkg::PH_J212_LEAD;
        end else begin
          dec.emit = 1'b1;
        end
      end
      jmbd_pkg::PH_J208: begin
        dec.emit = 1'b1;
        if (mode == jmbd_pkg::MODE_SJIS) begin
          if (sjis_ok) begin
            dec.kind  = jmbd_pkg::KIND_J208;
            dec.value = base + 16'(sjis_off);
          end
        end else if (euc_ok) begin
          dec.kind  = jmbd_pkg::KIND_J208;
          dec.value = base + 16'(euc_off);
        end
      end
      jmbd_pkg::PH_EUDC: begin
        dec.emit = 1'b1;
        if (sjis_ok) begin
          dec.value = base + 16'(sjis_off);
        end
      end
      jmbd_pkg::PH_REPLACE: begin
        dec.emit = 1'b1;
      end
      jmbd_pkg::PH_KANA: begin
        dec.emit = 1'b1;
        if (kana_ok) begin
          dec.value = kana_code;
        end
      end
      jmbd_pkg::PH_J212_LEAD: begin
        if (euc_ok) begin
          dec.base_nxt  = 16'(euc_off) * jmbd_pkg::EUC_ROW;
          dec.phase_nxt = jmbd_pkg::PH_J212_TRL;
        end else begin
          dec.phase_nxt = jmbd_pkg::PH_REPLACE;
        end
      end
      jmbd_pkg::PH_J212_TRL: begin
        dec.emit = 1'b1;
        if (euc_ok) begin
          dec.kind  = jmbd_pkg::KIND_J212;
          dec.value = base + 16'(euc_off);
        end
      end
      default: begin
        // unused phase code: drop the byte, return to lead
        dec.emit = 1'b0;
      end
    endcase
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the Shift_JIS / EUC-JP decoder top level.
// Needs jmbd_pkg, jmbd_in_if, jmbd_out_if and the block's RTL.
module tb;
  import jmbd_pkg::*;

  // Idle cycles with no item accepted on either side before giving up
  localparam int WATCHDOG_LIMIT = 5000;
  // Cycles to let a resultless lead byte clear the pipeline
  localparam int DRAIN_CYCLES   = 4;
  // Length of the one long receiver hold-off, and when it starts
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 150;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 85;
  localparam int MAX_PRINTS     = 40;
  localparam logic [7:0] TRAIL_NONE = 8'hFF;

  // One decoded code as it leaves the block
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
  } code_item_t;

  // Directed rows: mode write, predicted byte, byte typed with no code,
  // byte typed with its code
  typedef enum logic [1:0] {
    ROW_MODE,
    ROW_FREE,
    ROW_NONE,
    ROW_CODE
  } row_kind_t;

  typedef struct packed {
    row_kind_t   what;
    logic [7:0]  byte_val;
    logic [1:0]  kind;
    logic [15:0] value;
  } dir_row_t;

  localparam int NUM_ROWS = 33;
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // Shift_JIS after reset: ASCII extremes, dropped bytes, katakana top
    '{ROW_CODE, 8'h00, KIND_DIRECT, 16'h0000},
    '{ROW_CODE, 8'h7F, KIND_DIRECT, 16'h007F},
    '{ROW_NONE, 8'h80, KIND_DIRECT, 16'h0000},
    '{ROW_NONE, 8'hA0, KIND_DIRECT, 16'h0000},
    '{ROW_NONE, 8'hFF, KIND_DIRECT, 16'h0000},
    '{ROW_CODE, 8'hDF, KIND_DIRECT, 16'hFF9F},
    // first and last JIS0208 rows, trail extremes
    '{ROW_NONE, 8'h81, KIND_DIRECT, 16'h0000},
    '{ROW_CODE, 8'h40, KIND_J208,   16'h0000},
    '{ROW_NONE, 8'hEF, KIND_DIRECT, 16'h0000},
    '{ROW_FREE, 8'hFC, KIND_DIRECT, 16'h0000},
    // private-use lead, replace-next lead, bad trail
    '{ROW_NONE, 8'hF9, KIND_DIRECT, 16'h0000},
    '{ROW_FREE, 8'h7E, KIND_DIRECT, 16'h0000},
    '{ROW_NONE, 8'hFA, KIND_DIRECT, 16'h0000},
    '{ROW_CODE, 8'h41, KIND_DIRECT, REPLACEMENT},
    '{ROW_NONE, 8'h9F, KIND_DIRECT, 16'h0000},
    '{ROW_CODE, 8'h7F, KIND_DIRECT, REPLACEMENT},
    // EUC-JP: two-byte, katakana good and bad, JIS0212 good and bad
    '{ROW_MODE, 8'h01, KIND_DIRECT, 16'h0000},
    '{ROW_NONE, 8'hA1, KIND_DIRECT, 16'h0000},
    '{ROW_FREE, 8'hFE, KIND_DIRECT, 16'h0000},
    '{ROW_NONE, 8'h8E, KIND_DIRECT, 16'h0000},
    '{ROW_CODE, 8'hA1, KIND_DIRECT, 16'hFF61},
    '{ROW_NONE, 8'h8E, KIND_DIRECT, 16'h0000},
    '{ROW_CODE, 8'hE0, KIND_DIRECT, REPLACEMENT},
    '{ROW_NONE, 8'h8F, KIND_DIRECT, 16'h0000},
    '{ROW_NONE, 8'hFE, KIND_DIRECT, 16'h0000},
    '{ROW_FREE, 8'hA1, KIND_DIRECT, 16'h0000},
    '{ROW_NONE, 8'h8F, KIND_DIRECT, 16'h0000},
    '{ROW_NONE, 8'h00, KIND_DIRECT, 16'h0000},
    '{ROW_CODE, 8'h41, KIND_DIRECT, REPLACEMENT},
    // bad lead, then lead with bad trail
    '{ROW_CODE, 8'hA0, KIND_DIRECT, REPLACEMENT},
    '{ROW_NONE, 8'hFE, KIND_DIRECT, 16'h0000},
    '{ROW_CODE, 8'h7F, KIND_DIRECT, REPLACEMENT},
    '{ROW_MODE, 8'h00, KIND_DIRECT, 16'h0000}
  };

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  jmbd_in_if  in_ch ();
  jmbd_out_if out_ch ();

  japanese_multibyte_to_unicode_decoder_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Decoder shadow: mode register, phase and row base
  logic       dec_mode  = MODE_SJIS;
  phase_t     dec_phase = PH_LEAD;
  logic [15:0] dec_base = '0;

  code_item_t  pending_codes [$];
  logic [7:0]  char_bytes [$];
  int          mismatches     = 0;
  int          codes_received = 0;
  int          burst_left     = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drive every input known from time zero; hold reset low, then release it
  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.byte_in  <= 8'h00;
    out_ch.ready   <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Shift_JIS trail offset, TRAIL_NONE when the byte is no trail
  function automatic logic [7:0] sjis_trail_offset(input logic [7:0] b);
    if (b >= 8'h40 && b <= 8'h7E) return b - 8'h40;
    if (b >= 8'h80 && b <= 8'hFC) return b - 8'h41;
    return TRAIL_NONE;
  endfunction

  function automatic logic [7:0] euc_trail_offset(input logic [7:0] b);
    if (b >= 8'hA1 && b <= 8'hFE) return b - 8'hA1;
    return TRAIL_NONE;
  endfunction

  // Advance the shadow decoder by one byte; report whether a code comes out
  task automatic decode_next_byte(input logic [7:0] b, output bit emits,
                                  output code_item_t code);
    phase_t     ph;
    logic [7:0] off;
    ph         = dec_phase;
    dec_phase  = PH_LEAD;
    emits      = 1'b1;
    code.kind  = KIND_DIRECT;
    code.value = REPLACEMENT;
    case (ph)
      PH_LEAD: begin
        if (b <= ASCII_MAX) begin
          code.value = {8'h00, b};
        end else if (dec_mode == MODE_SJIS) begin
          emits = 1'b0;
          if (b >= 8'h81 && b <= 8'h9F) begin
            dec_base  = SJIS_ROW * (b - 8'h81);
            dec_phase = PH_J208;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            dec_base  = SJIS_ROW * (b - 8'hC1);
            dec_phase = PH_J208;
          end else if (b >= 8'hA1 && b <= 8'hDF) begin
            emits      = 1'b1;
            code.value = KANA_BIAS + b;
          end else if (b >= 8'hF0 && b <= 8'hF9) begin
            dec_base  = EUDC_BASE + SJIS_ROW * (b - 8'hF0);
            dec_phase = PH_EUDC;
          end else if (b >= 8'hFA && b <= 8'hFC) begin
            dec_phase = PH_REPLACE;
          end
        end else if (b >= 8'hA1 && b <= 8'hFE) begin
          emits     = 1'b0;
          dec_base  = EUC_ROW * (b - 8'hA1);
          dec_phase = PH_J208;
        end else if (b == EUC_SS2) begin
          emits     = 1'b0;
          dec_phase = PH_KANA;
        end else if (b == EUC_SS3) begin
          emits     = 1'b0;
          dec_phase = PH_J212_LEAD;
        end
      end
      PH_J208: begin
        off = (dec_mode == MODE_SJIS) ? sjis_trail_offset(b) : euc_trail_offset(b);
        if (off != TRAIL_NONE) begin
          code.kind  = KIND_J208;
          code.value = dec_base + off;
        end
      end
      PH_EUDC: begin
        off = sjis_trail_offset(b);
        if (off != TRAIL_NONE) code.value = dec_base + off;
      end
      PH_REPLACE: ;
      PH_KANA: begin
        if (b >= 8'hA1 && b <= 8'hDF) code.value = KANA_BIAS + b;
      end
      PH_J212_LEAD: begin
        emits = 1'b0;
        if (b >= 8'hA1 && b <= 8'hFE) begin
          dec_base  = EUC_ROW * (b - 8'hA1);
          dec_phase = PH_J212_TRL;
        end else begin
          dec_phase = PH_REPLACE;
        end
      end
      PH_J212_TRL: begin
        off = euc_trail_offset(b);
        if (off != TRAIL_NONE) begin
          code.kind  = KIND_J212;
          code.value = dec_base + off;
        end
      end
      default: emits = 1'b0;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  // Hold off until every predicted code has left the block
  task automatic wait_for_all_codes();
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  // Offer one byte in a sender burst. Between bursts drop valid for a random gap,
  // which may be empty; within a burst keep valid high from one item to the next.
  task automatic offer_byte(input logic [7:0] b, input row_kind_t how,
                            input code_item_t typed_code);
    int         gap;
    bit         emits;
    code_item_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.byte_in <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // Accepted at this edge: advance the shadow and file the expectation
    decode_next_byte(b, emits, predicted);
    case (how)
      ROW_NONE: ;
      ROW_CODE: pending_codes.push_back(typed_code);
      default:  if (emits) pending_codes.push_back(predicted);
    endcase
  endtask

  // Write the mode register only with the block idle; the write also
  // sends the decoder back to the lead phase
  task automatic set_encoding_mode(input logic m);
    in_ch.valid <= 1'b0;
    wait_for_all_codes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dec_mode   = m;
    dec_phase  = PH_LEAD;
    dec_base   = '0;
    burst_left = 0;
  endtask

  function automatic logic [7:0] pick_sjis_trail();
    logic [7:0] off;
    off = 8'($urandom_range(0, 187));
    return (off < 8'd63) ? 8'h40 + off : 8'h41 + off;
  endfunction

  // Any byte that is no Shift_JIS trail: 00-3F, 7F, FD-FF
  function automatic logic [7:0] pick_bad_sjis_trail();
    logic [7:0] r;
    r = 8'($urandom_range(0, 67));
    if (r < 8'd64) return r;
    if (r == 8'd64) return 8'h7F;
    return 8'hFD + (r - 8'd65);
  endfunction

  function automatic logic [7:0] pick_euc_byte();
    return 8'($urandom_range(8'hA1, 8'hFE));
  endfunction

  // Queue the bytes of one random character; mostly well formed, with
  // broken sequences and raw noise mixed in
  task automatic queue_random_char(input logic m);
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      char_bytes.push_back(8'($urandom_range(0, 8'h7F)));
    end else if (m == MODE_SJIS) begin
      if (r < 32) begin
        char_bytes.push_back(8'($urandom_range(8'hA1, 8'hDF)));
      end else if (r < 62) begin
        char_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9F))
                                                  : 8'($urandom_range(8'hE0, 8'hEF)));
        char_bytes.push_back(pick_sjis_trail());
      end else if (r < 72) begin
        char_bytes.push_back(8'($urandom_range(8'hF0, 8'hF9)));
        char_bytes.push_back(pick_sjis_trail());
      end else if (r < 78) begin
        char_bytes.push_back(8'($urandom_range(8'hFA, 8'hFC)));
        char_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 88) begin
        char_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9F))
                                                  : 8'($urandom_range(8'hF0, 8'hF9)));
        char_bytes.push_back(pick_bad_sjis_trail());
      end else begin
        char_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      if (r < 55) begin
        char_bytes.push_back(pick_euc_byte());
        char_bytes.push_back(pick_euc_byte());
      end else if (r < 67) begin
        char_bytes.push_back(EUC_SS2);
        char_bytes.push_back(8'($urandom_range(8'hA1, 8'hDF)));
      end else if (r < 79) begin
        char_bytes.push_back(EUC_SS3);
        char_bytes.push_back(pick_euc_byte());
        char_bytes.push_back(pick_euc_byte());
      end else if (r < 85) begin
        // single-shift with random, mostly broken, continuation
        char_bytes.push_back($urandom_range(0, 1) ? EUC_SS2 : EUC_SS3);
        char_bytes.push_back(8'($urandom_range(0, 255)));
        char_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 91) begin
        char_bytes.push_back(pick_euc_byte());
        char_bytes.push_back($urandom_range(0, 7) == 0 ? 8'hFF
                                                       : 8'($urandom_range(0, 8'hA0)));
      end else begin
        char_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Result side: compare every accepted code with the oldest prediction
  always @(posedge clk) begin : check_codes
    code_item_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      codes_received++;
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("unexpected code: kind %0d value %h",
                                  out_ch.result_kind, out_ch.code_value));
      end else begin
        want = pending_codes.pop_front();
        if (out_ch.result_kind !== want.kind)
          report_mismatch($sformatf("result_kind: got %0d, want %0d",
                                    out_ch.result_kind, want.kind));
        if (out_ch.code_value !== want.value)
          report_mismatch($sformatf("code_value: got %h, want %h",
                                    out_ch.code_value, want.value));
      end
    end
  end

  // Receiver: stall in one of four random styles; once, after enough
  // codes have come, hold ready low long enough to back up the input
  initial begin : result_sink
    int cyc       = 0;
    int style     = 0;
    int hold_left = 0;
    bit held      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 50 == 0) style = $urandom_range(0, 3);
      if (!held && codes_received >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= (cyc % 4 == 0);
          default: out_ch.ready <= (cyc % 8 != 0);
        endcase
      end
    end
  end

  // Watchdog: end the run when neither side moves an item for too long
  initial begin : watchdog
    int idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("japanese_multibyte_to_unicode_decoder_unit: mismatch");
    $finish;
  end

  // Sender: directed table first, then random phases alternating mode
  initial begin : byte_source
    int  sent;
    bit  paused;
    code_item_t typed_code;
    paused = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      typed_code.kind  = DIRECTED_ROWS[i].kind;
      typed_code.value = DIRECTED_ROWS[i].value;
      if (DIRECTED_ROWS[i].what == ROW_MODE)
        set_encoding_mode(DIRECTED_ROWS[i].byte_val[0]);
      else
        offer_byte(DIRECTED_ROWS[i].byte_val, DIRECTED_ROWS[i].what, typed_code);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_encoding_mode((ph % 2 == 0) ? 1'b1 : MODE_SJIS);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Once, stop mid-phase and let every pending code drain
        if (ph == 2 && sent >= 40 && !paused) begin
          paused = 1'b1;
          in_ch.valid <= 1'b0;
          wait_for_all_codes();
          burst_left = 0;
        end
        queue_random_char(dec_mode);
        while (char_bytes.size() != 0) begin
          offer_byte(char_bytes.pop_front(), ROW_FREE, '0);
          sent++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    wait_for_all_codes();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("japanese_multibyte_to_unicode_decoder_unit: match");
    else
      $display("japanese_multibyte_to_unicode_decoder_unit: mismatch");
    $finish;
  end

endmodule
